[hw/rtl/hps_pkg.sv]
// Shared types and constants for the host power sequencer.
`timescale 1ns / 1ps

package hps_pkg;

    // Configuration data width and the default elapsed-counter width
    localparam int CFG_W         = 20;
    localparam int TIMER_W_DEF   = 20;
    localparam int CFG_IDX_W     = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_TIME     = 2'd0,
        REG_SHUTDOWN_DELAY = 2'd1,
        REG_STARTUP_TIME   = 2'd2
    } t_reg_idx;

    // Reset values of the registers, in milliseconds
    localparam logic [CFG_W-1:0] PRESS_TIME_RST     = 20'd500;
    localparam logic [CFG_W-1:0] SHUTDOWN_DELAY_RST = 20'd30000;
    localparam logic [CFG_W-1:0] STARTUP_TIME_RST   = 20'd60000;

    typedef struct packed {
        logic [CFG_W-1:0] press_time;
        logic [CFG_W-1:0] shutdown_delay;
        logic [CFG_W-1:0] startup_time;
    } t_cfg;

    typedef struct packed {
        logic button_drive;
        logic full_power;
        logic off_pending;
        logic cut_pending;
    } t_result;

endpackage

[hw/rtl/hps_cfg_regs.sv]
// Configuration register file of the host power sequencer.
`timescale 1ns / 1ps

module hps_cfg_regs
    import hps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PRESS_TIME:     n_cfg.press_time     = i_cfg_data;
                REG_SHUTDOWN_DELAY: n_cfg.shutdown_delay = i_cfg_data;
                REG_STARTUP_TIME:   n_cfg.startup_time   = i_cfg_data;
                default:            n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_time     <= PRESS_TIME_RST;
            r_cfg.shutdown_delay <= SHUTDOWN_DELAY_RST;
            r_cfg.startup_time   <= STARTUP_TIME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hw/rtl/hps_core.sv]
// Sequencing state and per-request update logic of the host power sequencer.
`timescale 1ns / 1ps

module hps_core
    import hps_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_tick,
    input  logic    i_on_request,
    input  logic    i_off_request,
    input  logic    i_sense_on,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic                   r_pulse_active,    n_pulse_active;
    logic [TIMER_WIDTH-1:0] r_pulse_elapsed,   n_pulse_elapsed;
    logic                   r_cut_waiting,     n_cut_waiting;
    logic [TIMER_WIDTH-1:0] r_cut_elapsed,     n_cut_elapsed;
    logic                   r_off_waiting,     n_off_waiting;
    logic [TIMER_WIDTH-1:0] r_startup_elapsed, n_startup_elapsed;
    logic                   r_relay_closed,    n_relay_closed;

    logic [TIMER_WIDTH-1:0] pulse_t, cut_t, startup_t;

    // Advance the elapsed counters on a tick, holding at full scale
    assign pulse_t   = (i_tick && r_pulse_elapsed != TMAX)
                       ? r_pulse_elapsed + 1'b1 : r_pulse_elapsed;
    assign cut_t     = (i_tick && r_cut_elapsed != TMAX)
                       ? r_cut_elapsed + 1'b1 : r_cut_elapsed;
    assign startup_t = (i_tick && r_startup_elapsed != TMAX)
                       ? r_startup_elapsed + 1'b1 : r_startup_elapsed;

    always_comb begin
        n_pulse_active    = r_pulse_active;
        n_pulse_elapsed   = pulse_t;
        n_cut_waiting     = r_cut_waiting;
        n_cut_elapsed     = cut_t;
        n_off_waiting     = r_off_waiting | i_off_request;
        n_startup_elapsed = startup_t;
        n_relay_closed    = r_relay_closed;

        // Release the button once the press time is reached
        if (n_pulse_active && CMP_W'(pulse_t) >= CMP_W'(i_cfg.press_time)) begin
            n_pulse_active = 1'b0;
        end

        // Open the relay when the graceful-shutdown delay has run out
        if (n_cut_waiting && CMP_W'(cut_t) >= CMP_W'(i_cfg.shutdown_delay)) begin
            n_cut_waiting  = 1'b0;
            n_relay_closed = 1'b0;
        end

        // An on request is served in the pass that brings it
        if (i_on_request) begin
            if (!i_sense_on) begin
                n_pulse_active  = 1'b1;
                n_pulse_elapsed = '0;
            end
            n_cut_waiting     = 1'b0;
            n_relay_closed    = 1'b1;
            n_startup_elapsed = '0;
        end

        if (n_off_waiting &&
            CMP_W'(n_startup_elapsed) >= CMP_W'(i_cfg.startup_time)) begin
            if (i_sense_on) begin
                n_pulse_active  = 1'b1;
                n_pulse_elapsed = '0;
                n_cut_waiting   = 1'b1;
                n_cut_elapsed   = '0;
            end
            n_off_waiting = 1'b0;
        end
    end

    assign o_result.button_drive = n_pulse_active;
    assign o_result.full_power   = n_relay_closed;
    assign o_result.off_pending  = n_off_waiting;
    assign o_result.cut_pending  = n_cut_waiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_active    <= 1'b0;
            r_pulse_elapsed   <= '0;
            r_cut_waiting     <= 1'b0;
            r_cut_elapsed     <= '0;
            r_off_waiting     <= 1'b0;
            r_startup_elapsed <= '0;
            r_relay_closed    <= 1'b0;
        end else if (i_accept) begin
            r_pulse_active    <= n_pulse_active;
            r_pulse_elapsed   <= n_pulse_elapsed;
            r_cut_waiting     <= n_cut_waiting;
            r_cut_elapsed     <= n_cut_elapsed;
            r_off_waiting     <= n_off_waiting;
            r_startup_elapsed <= n_startup_elapsed;
            r_relay_closed    <= n_relay_closed;
        end
    end

endmodule

[hw/rtl/hps_out_buf.sv]
// Result register with a skid stage for the host power sequencer.
`timescale 1ns / 1ps

module hps_out_buf
    import hps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_full,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop         = r_out_valid & ~i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out <= i_result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out       <= i_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

[hw/rtl/host_power_sequencer_unit.sv]
// Top level of the host power sequencer.
`timescale 1ns / 1ps

// Host power sequencer: drives an emulated power button and the main power
// relay of an attached computer. Each request carries an optional millisecond
// tick, switch-on and switch-off requests and the sensed running level, and
// yields one result with the button, relay and pending flags as they stand
// after that request. The state update is a single pass of timer compares
// between the state registers and the result register, so a new request is
// taken every cycle while results drain. Results sit in a result register
// backed by one skid entry; o_in_stall rises only when both hold results
// that the downstream side has not taken. Timers are saturating elapsed
// counters of TIMER_WIDTH bits; a configured time the counter cannot reach
// never fires. Configuration writes are always ready and must be made
// while no request is in flight.
module host_power_sequencer_unit
    import hps_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_tick,
    input  logic                 i_on_request,
    input  logic                 i_off_request,
    input  logic                 i_sense_on,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_button_drive,
    output logic                 o_full_power,
    output logic                 o_off_pending,
    output logic                 o_cut_pending,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    buf_full;
    logic    accept;

    // Take a request whenever the skid entry is free
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid & ~buf_full;

    hps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Update sequencing state and form the result in the accepting cycle
    hps_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_tick        (i_tick),
        .i_on_request  (i_on_request),
        .i_off_request (i_off_request),
        .i_sense_on    (i_sense_on),
        .i_cfg         (cfg),
        .o_result      (core_result)
    );

    hps_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_button_drive = out_result.button_drive;
    assign o_full_power   = out_result.full_power;
    assign o_off_pending  = out_result.off_pending;
    assign o_cut_pending  = out_result.cut_pending;

endmodule

[hw/rtl/hps_checker.sv]
// Port-level assertions for the host power sequencer, bound to the top level.
`timescale 1ns / 1ps

module hps_port_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_button_drive,
    input logic o_full_power,
    input logic o_off_pending,
    input logic o_cut_pending
);

    // A stall toward the requester means both result slots are occupied
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("request stall without a pending result");

    // A request taken while the result is held fills the skid entry
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && o_out_valid && i_out_stall) |=> o_in_stall)
        else $error("skid entry not filled");

    // Drop any result after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("result present after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid
            && $stable(o_button_drive) && $stable(o_full_power)
            && $stable(o_off_pending) && $stable(o_cut_pending)))
        else $error("stalled result changed");

endmodule

bind host_power_sequencer_unit hps_port_props u_hps_port_props (.*);

[tb/sv/hps_checker.sv]
// Result checker for the host power sequencer: mirrors its state and checks every result.
`timescale 1ns / 1ps

module hps_checker
    import hps_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_tick,
    input  logic                 i_on_request,
    input  logic                 i_off_request,
    input  logic                 i_sense_on,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_button_drive,
    input  logic                 i_full_power,
    input  logic                 i_off_pending,
    input  logic                 i_cut_pending,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_err_count,
    output int                   o_outstanding,
    output int                   o_checked
);

    typedef logic [TIMER_WIDTH-1:0] t_age;

    // mirrored registers and sequencer state
    t_cfg    cfg;
    logic    btn_on;
    logic    cut_armed;
    logic    off_wait;
    logic    relay;
    t_age    btn_age;
    t_age    cut_age;
    t_age    boot_age;

    t_result pending_levels[$];
    int      errors  = 0;
    int      checked = 0;

    function automatic t_age age_up(input t_age a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    function automatic logic reached(input t_age a, input logic [CFG_W-1:0] limit);
        return 64'(a) >= 64'(limit);
    endfunction

    // one pass of the sequencer; returns the levels it leaves behind
    function automatic t_result next_levels(input logic tick, input logic on_req,
                                            input logic off_req, input logic sense);
        t_result r;
        if (tick) begin
            btn_age  = age_up(btn_age);
            cut_age  = age_up(cut_age);
            boot_age = age_up(boot_age);
        end
        if (off_req) off_wait = 1'b1;
        if (btn_on && reached(btn_age, cfg.press_time)) btn_on = 1'b0;
        if (cut_armed && reached(cut_age, cfg.shutdown_delay)) begin
            cut_armed = 1'b0;
            relay     = 1'b0;
        end
        if (on_req) begin
            if (!sense) begin
                btn_on  = 1'b1;
                btn_age = '0;
            end
            cut_armed = 1'b0;
            relay     = 1'b1;
            boot_age  = '0;
        end
        if (off_wait && reached(boot_age, cfg.startup_time)) begin
            if (sense) begin
                btn_on    = 1'b1;
                btn_age   = '0;
                cut_armed = 1'b1;
                cut_age   = '0;
            end
            off_wait = 1'b0;
        end
        r.button_drive = btn_on;
        r.full_power   = relay;
        r.off_pending  = off_wait;
        r.cut_pending  = cut_armed;
        return r;
    endfunction

    task automatic check_bit(input string name, input logic want, input logic seen);
        if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            cfg       = '{PRESS_TIME_RST, SHUTDOWN_DELAY_RST, STARTUP_TIME_RST};
            btn_on    = 1'b0;
            cut_armed = 1'b0;
            off_wait  = 1'b0;
            relay     = 1'b0;
            btn_age   = '0;
            cut_age   = '0;
            boot_age  = '0;
            pending_levels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PRESS_TIME:     cfg.press_time     = i_cfg_data;
                    REG_SHUTDOWN_DELAY: cfg.shutdown_delay = i_cfg_data;
                    REG_STARTUP_TIME:   cfg.startup_time   = i_cfg_data;
                    default: ;
                endcase
            end
            // a result can never belong to a request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_button_drive, i_full_power, i_off_pending, i_cut_pending};
                if (pending_levels.size() == 0) begin
                    errors++;
                    $display("%0t: result %b arrived with none expected", $time, seen);
                end else begin
                    want = pending_levels.pop_front();
                    checked++;
                    check_bit("button_drive", want.button_drive, seen.button_drive);
                    check_bit("full_power", want.full_power, seen.full_power);
                    check_bit("off_pending", want.off_pending, seen.off_pending);
                    check_bit("cut_pending", want.cut_pending, seen.cut_pending);
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_levels.push_back(next_levels(i_tick, i_on_request,
                                                     i_off_request, i_sense_on));
        end
        o_err_count   <= errors;
        o_outstanding <= pending_levels.size();
        o_checked     <= checked;
    end

endmodule

[tb/sv/tb.sv]
// Top of the host power sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import hps_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int GAP_MAX      = 18;
    // far above the longest quiet stretch of a correct run (gap plus stall plus drain)
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 4;

    // one request as seen on the request channel
    typedef struct packed {
        logic tick;
        logic on_req;
        logic off_req;
        logic sense;
    } t_pass;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel, driven from the first instant
    logic in_valid = 1'b0;
    logic tick     = 1'b0;
    logic on_req   = 1'b0;
    logic off_req  = 1'b0;
    logic sense    = 1'b0;
    logic in_stall;

    // result channel
    logic out_valid;
    logic out_stall = 1'b0;
    logic button_drive;
    logic full_power;
    logic off_pending;
    logic cut_pending;

    // configuration channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // idling bounds of the two sides, changed per phase
    int   in_gap_max  = GAP_MAX;
    int   out_gap_max = GAP_MAX;

    int   sent        = 0;
    int   settings    = 0;
    int   quiet       = 0;
    int   err_count;
    int   outstanding;
    int   checked;

    // sensed host level used by the random requests; wanders slowly
    logic host_up = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    host_power_sequencer_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_tick         (tick),
        .i_on_request   (on_req),
        .i_off_request  (off_req),
        .i_sense_on     (sense),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_button_drive (button_drive),
        .o_full_power   (full_power),
        .o_off_pending  (off_pending),
        .o_cut_pending  (cut_pending),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    hps_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_tick         (tick),
        .i_on_request   (on_req),
        .i_off_request  (off_req),
        .i_sense_on     (sense),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_button_drive (button_drive),
        .i_full_power   (full_power),
        .i_off_pending  (off_pending),
        .i_cut_pending  (cut_pending),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_err_count    (err_count),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    // Watchdog: count cycles where nothing moves on any channel and give up
    // once the count reaches the limit.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Result side: hold stall for a drawn number of cycles, then drop it until
    // one result is taken. Raise stall only when the draw is nonzero, so stall
    // never gets two assignments in one step.
    initial begin
        int unsigned hold;
        forever begin
            hold = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Present one request after a drawn gap and hold it until it is taken.
    // Drop valid only for a real gap; back-to-back requests keep it high.
    task automatic send_request(input t_pass p);
        int unsigned gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {tick, on_req, off_req, sense} <= p;
        do @(posedge clk); while (!(in_valid && !in_stall));
        sent++;
    endtask

    // Stop sending and wait until every expected result has come back, then
    // let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // Write all three timing registers back to back; only call while idle.
    task automatic load_config(input logic [CFG_W-1:0] press, input logic [CFG_W-1:0] shut,
                               input logic [CFG_W-1:0] boot);
        write_reg(REG_PRESS_TIME, press);
        write_reg(REG_SHUTDOWN_DELAY, shut);
        write_reg(REG_STARTUP_TIME, boot);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly well-formed traffic: frequent ticks, occasional on and off
    // requests, and a sensed level that follows a slowly wandering host with
    // a little noise on top.
    function automatic t_pass random_pass();
        t_pass p;
        if ($urandom_range(0, 11) == 0) host_up = ~host_up;
        p.tick    = ($urandom_range(0, 3) != 0);
        p.on_req  = ($urandom_range(0, 9) == 0);
        p.off_req = ($urandom_range(0, 7) == 0);
        p.sense   = ($urandom_range(0, 19) == 0) ? ~host_up : host_up;
        return p;
    endfunction

    initial begin
        t_pass script[$];
        logic [CFG_W-1:0] press;
        logic [CFG_W-1:0] shut;
        logic [CFG_W-1:0] boot;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timings: an idle pass, a switch-on with the host down, then
        // an early switch-off that must wait out the long startup time.
        script = '{4'b0000, 4'b0100, 4'b1010};
        foreach (script[i]) send_request(script[i]);
        settle();

        // Short timings: walk through the ordinary on/off cycle and its corners.
        load_config(20'd2, 20'd3, 20'd2);
        script = '{
            4'b1000, 4'b1001, 4'b1001,          // let startup run out, host up
            4'b1011,                            // off acts: press and arm the cut
            4'b1001, 4'b1001, 4'b1001, 4'b1001, // release press, then cut power
            4'b1110,                            // on and off together, host down
            4'b1101,                            // on again while the relay is closed
            4'b1000, 4'b1000, 4'b1000,          // held off with host down is dropped
            4'b1011,                            // new off with host running
            4'b1111,                            // on cancels the pending cut
            4'b0100                             // press while still pressed
        };
        foreach (script[i]) send_request(script[i]);
        settle();

        // Zero timings: everything takes effect on the first pass that checks it.
        load_config('0, '0, '0);
        script = '{4'b0111, 4'b0000, 4'b0110, 4'b1000};
        foreach (script[i]) send_request(script[i]);

        // Random phases, each with its own timing set and idling pattern.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin in_gap_max = GAP_MAX; out_gap_max = GAP_MAX; end
                1: begin in_gap_max = 0;       out_gap_max = 0;       end
                2: begin in_gap_max = GAP_MAX; out_gap_max = 0;       end
                default: begin in_gap_max = 0; out_gap_max = GAP_MAX; end
            endcase
            case (ph)
                0: begin
                    // full-range values: most timers never expire
                    press = CFG_W'($urandom());
                    shut  = CFG_W'($urandom());
                    boot  = CFG_W'($urandom());
                end
                1: begin
                    press = '1;
                    shut  = '1;
                    boot  = '1;
                end
                2: begin
                    press = '0;
                    shut  = '1;
                    boot  = CFG_W'($urandom_range(0, 6));
                end
                default: begin
                    press = CFG_W'($urandom_range(0, 10));
                    shut  = CFG_W'($urandom_range(0, 12));
                    boot  = CFG_W'($urandom_range(0, 10));
                end
            endcase
            load_config(press, shut, boot);
            repeat (RANDOM_ITEMS / PHASES) send_request(random_pass());
        end
        settle();

        $display("Covered %0d requests and %0d checked results over %0d timing settings,",
                 sent, checked, settings);
        $display("with random gaps and stalls on each side as well as full-rate stretches.");
        if (err_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
